[hw/rtl/nfpr_pkg.sv]
// Shared types and constants for the NOR flash program/read model.
// Used by every module under hw/rtl; no dependencies of its own.
`timescale 1ns / 1ps
package nfpr_pkg;

  localparam int ADDR_W     = 17;
  localparam int RLEN_W     = 7;
  localparam int PFX_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int PAGE_W     = 9;
  localparam int TOT_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int PAGE_MAX_DEF  = 256;
  localparam int READ_MAX_DEF  = 64;

  localparam logic [TOT_W-1:0]  TOTAL_RST = 17'd65536;
  localparam logic [PAGE_W-1:0] PAGE_RST  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_BYTES = 1'b0,
    CFG_PAGE_BYTES  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OOB    = 3'd1,
    ST_PAGE   = 3'd2,
    ST_BITS   = 3'd3,
    ST_PREFIX = 3'd4
  } status_t;

  typedef struct packed {
    logic               action;
    logic [ADDR_W-1:0]  address;
    logic [RLEN_W-1:0]  read_length;
    logic [PFX_W-1:0]   prefix_count;
    logic [BYTE_W-1:0]  data_byte;
    logic               burst_end;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  read_data;
    logic [PFX_W-1:0]   programmed_count;
    logic               interrupted;
    logic               last_of_run;
  } out_item_t;

  // flash port command
  typedef struct packed {
    logic re;
    logic we;
  } flash_cmd_t;

endpackage

[hw/rtl/nfpr_flash.sv]
// Flash byte array: single-port synchronous RAM with a registered read.
// Sweeps every entry to the erased value after reset. Depends on nfpr_pkg.
`timescale 1ns / 1ps
module nfpr_flash
  import nfpr_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  flash_cmd_t        cmd,
  input  logic [AW-1:0]     addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata,
  output logic              busy
);

  logic [BYTE_W-1:0] mem [MEM_BYTES];
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              busy_r, busy_nxt;
  logic [BYTE_W-1:0] rdata_r;

  always_comb begin
    clr_nxt  = clr_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      clr_nxt = clr_r + 1'b1;
      if (clr_r == AW'(MEM_BYTES - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      busy_r <= 1'b1;
    end else begin
      clr_r  <= clr_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= {BYTE_W{1'b1}};
    end else if (cmd.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re && !busy_r) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

[hw/rtl/nfpr_page_rem.sv]
// Iterative remainder of a start address by the page size, one bit a cycle.
// A start while busy restarts with the new operands. Depends on nfpr_pkg.
`timescale 1ns / 1ps
module nfpr_page_rem
  import nfpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  input  logic [PAGE_W-1:0] divisor,
  output logic              done,
  output logic [PAGE_W-1:0] rem
);

  localparam int CNT_W = $clog2(ADDR_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] q_r, q_nxt;
  logic [PAGE_W-1:0] rem_r, rem_nxt;
  logic [PAGE_W-1:0] div_r, div_nxt;
  logic [PAGE_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, q_r[ADDR_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // restoring step: shift in next dividend bit, subtract if it fits
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = PAGE_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[PAGE_W-1:0];
      end
      q_nxt   = {q_r[ADDR_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ADDR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[hw/rtl/nor_flash_program_read_model_unit.sv]
// Top level: NOR flash program/read model with page buffer and check sequencer.
// Depends on nfpr_pkg, nfpr_flash, nfpr_page_rem.
//
//   channel   dir  handshake              payload
//   in_       in   in_valid / in_ready    in_item_t   (read request or program byte)
//   out_      out  out_valid / out_ready  out_item_t  (one beat per result)
//   cfg_      in   cfg_we                 cfg_index, cfg_wdata
//
// Reset runs a clearing pass over every flash entry; in_ready stays low until it ends.
// Each beat is taken in S_IDLE, and a mid-burst byte needs nothing more. A read of N bytes
// visits S_RD_ADDR (flash read) then S_RD_DATA (output load) for each byte; a read with
// one status beat goes to S_RES. A burst that passes its checks goes through S_CHECK, S_REM
// for the page remainder, S_VAL_ADDR/S_VAL_CHK for each burst byte's bit check, S_COM_ADDR/
// S_COM_WR for each prefix byte's commit read-modify-write, and S_RES. A stalled output beat holds the sequencer.
`timescale 1ns / 1ps
module nor_flash_program_read_model_unit
  import nfpr_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int PAGE_MAX  = PAGE_MAX_DEF,
  parameter int READ_MAX  = READ_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW   = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int AXW  = (AW > 18) ? AW : 18;
  localparam int PW   = (PAGE_MAX > 1) ? $clog2(PAGE_MAX) : 1;
  localparam int CW   = $clog2(PAGE_MAX + 1);
  localparam int RLW  = $clog2(READ_MAX + 1);
  localparam int MAXN = (PAGE_MAX > READ_MAX) ? PAGE_MAX : READ_MAX;
  localparam int IW   = $clog2(MAXN + 1);
  localparam int CMW  = ((IW > PFX_W) ? IW : PFX_W) + 1;
  localparam int XW   = ((CW > PAGE_W) ? CW : PAGE_W) + 1;

  localparam logic [17:0]       MEM_CAP = (MEM_BYTES > 131071) ? 18'd131071 : 18'(MEM_BYTES);
  localparam logic [PAGE_W-1:0] PG_CAP  = (PAGE_MAX > 511) ? 9'd511 : PAGE_W'(PAGE_MAX);
  localparam logic [RLEN_W-1:0] RMAX    = RLEN_W'(READ_MAX);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_RD_ADDR  = 10'b00_0000_0010,
    S_RD_DATA  = 10'b00_0000_0100,
    S_CHECK    = 10'b00_0000_1000,
    S_REM      = 10'b00_0001_0000,
    S_VAL_ADDR = 10'b00_0010_0000,
    S_VAL_CHK  = 10'b00_0100_0000,
    S_COM_ADDR = 10'b00_1000_0000,
    S_COM_WR   = 10'b01_0000_0000,
    S_RES      = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [RLW-1:0]      rd_len_r, rd_len_nxt;
  logic [CW-1:0]       b_count_r, b_count_nxt;
  logic [ADDR_W-1:0]   b_start_r, b_start_nxt;
  logic [PFX_W-1:0]    b_prefix_r, b_prefix_nxt;
  logic                b_ovf_r, b_ovf_nxt;
  logic                fin_r, fin_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [PFX_W-1:0]    res_pc_r, res_pc_nxt;
  logic                res_intr_r, res_intr_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [TOT_W-1:0]    total_r;
  logic [PAGE_W-1:0]   page_r;

  logic [BYTE_W-1:0]   pbuf [PAGE_MAX];
  logic [BYTE_W-1:0]   pb_rdata_r;
  logic                pb_we, pb_re;

  flash_cmd_t          fl_cmd;
  logic [AW-1:0]       fl_addr;
  logic [BYTE_W-1:0]   fl_wdata, fl_rdata;
  logic                fl_busy;

  logic                rem_start, rem_done;
  logic [PAGE_W-1:0]   rem_val;

  logic                in_fire, is_read, out_free, first_byte;
  logic [TOT_W-1:0]    eff_tot;
  logic [PAGE_W-1:0]   page_eff;
  logic [RLEN_W-1:0]   rlen_sat;
  logic                rd_oob, b_oob, b_cross, bit_bad;
  logic [17:0]         rd_sum, b_sum;
  logic [AXW-1:0]      rd_ext, b_ext;
  logic [CMW-1:0]      idx_inc;

  // --- configuration registers -------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RST;
      page_r  <= PAGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TOTAL_BYTES: total_r <= cfg_wdata[TOT_W-1:0];
        CFG_PAGE_BYTES:  page_r  <= cfg_wdata[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_tot  = ({1'b0, total_r} > MEM_CAP) ? MEM_CAP[TOT_W-1:0] : total_r;
  assign page_eff = (page_r == '0) ? PAGE_W'(1) : ((page_r > PG_CAP) ? PG_CAP : page_r);

  // --- datapath helpers ----------------------------------------------------
  assign in_ready   = (state_r == S_IDLE) && !fl_busy;
  assign in_fire    = in_valid && in_ready;
  assign is_read    = !in_data.action && !in_data.burst_end;
  assign out_free   = !out_valid_r || out_ready;
  assign first_byte = (b_count_r == '0) && !b_ovf_r;

  assign rlen_sat = (in_data.read_length > RMAX) ? RMAX : in_data.read_length;
  assign rd_oob   = ({1'b0, in_data.address} + 18'(rlen_sat)) > {1'b0, eff_tot};
  assign b_oob    = ({1'b0, b_start_r} + 18'(b_count_r)) > {1'b0, eff_tot};
  assign b_cross  = (XW'(rem_val) + XW'(b_count_r)) > XW'(page_eff);
  assign bit_bad  = (fl_rdata & pb_rdata_r) != pb_rdata_r;
  assign idx_inc  = CMW'(idx_r) + 1'b1;

  assign rd_sum  = {1'b0, rd_addr_r} + 18'(idx_r);
  assign b_sum   = {1'b0, b_start_r} + 18'(idx_r);
  assign rd_ext  = AXW'(rd_sum);
  assign b_ext   = AXW'(b_sum);
  assign fl_addr = (state_r == S_RD_ADDR) ? rd_ext[AW-1:0] : b_ext[AW-1:0];

  assign fl_cmd.re = (state_r == S_RD_ADDR) || (state_r == S_VAL_ADDR)
                  || (state_r == S_COM_ADDR);
  assign fl_cmd.we = (state_r == S_COM_WR);
  assign fl_wdata  = fl_rdata & pb_rdata_r;

  assign pb_we = in_fire && !is_read && in_data.action && (b_count_r < CW'(PAGE_MAX));
  assign pb_re = (state_r == S_VAL_ADDR) || (state_r == S_COM_ADDR);

  // --- page buffer memory --------------------------------------------------
  always_ff @(posedge clk) begin
    if (pb_we) begin
      pbuf[b_count_r[PW-1:0]] <= in_data.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (pb_re) begin
      pb_rdata_r <= pbuf[idx_r[PW-1:0]];
    end
  end

  // --- sequencer -----------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rd_addr_nxt    = rd_addr_r;
    rd_len_nxt     = rd_len_r;
    b_count_nxt    = b_count_r;
    b_start_nxt    = b_start_r;
    b_prefix_nxt   = b_prefix_r;
    b_ovf_nxt      = b_ovf_r;
    fin_nxt        = fin_r;
    res_status_nxt = res_status_r;
    res_pc_nxt     = res_pc_r;
    res_intr_nxt   = res_intr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    rem_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (is_read) begin
            res_pc_nxt   = '0;
            res_intr_nxt = 1'b0;
            fin_nxt      = 1'b0;
            if (rd_oob) begin
              res_status_nxt = ST_OOB;
              state_nxt      = S_RES;
            end else if (rlen_sat == '0) begin
              res_status_nxt = ST_OK;
              state_nxt      = S_RES;
            end else begin
              rd_addr_nxt = in_data.address;
              rd_len_nxt  = RLW'(rlen_sat);
              idx_nxt     = '0;
              state_nxt   = S_RD_ADDR;
            end
          end else begin
            if (first_byte) begin
              b_start_nxt  = in_data.address;
              b_prefix_nxt = in_data.prefix_count;
            end
            if (in_data.action) begin
              if (pb_we) begin
                b_count_nxt = b_count_r + 1'b1;
              end else begin
                b_ovf_nxt = 1'b1;
              end
            end
            if (in_data.burst_end) begin
              fin_nxt   = 1'b1;
              state_nxt = S_CHECK;
            end
          end
        end
      end
      S_RD_ADDR: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, read_data: fl_rdata, programmed_count: '0,
                            interrupted: 1'b0,
                            last_of_run: (idx_inc == CMW'(rd_len_r))};
          if (idx_inc == CMW'(rd_len_r)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD_ADDR;
          end
        end
      end
      S_CHECK: begin
        res_pc_nxt   = '0;
        res_intr_nxt = 1'b0;
        if (b_ovf_r) begin
          res_status_nxt = ST_PAGE;
          state_nxt      = S_RES;
        end else if (CMW'(b_prefix_r) > CMW'(b_count_r)) begin
          res_status_nxt = ST_PREFIX;
          state_nxt      = S_RES;
        end else if (b_oob) begin
          res_status_nxt = ST_OOB;
          state_nxt      = S_RES;
        end else if (b_count_r == '0) begin
          // empty burst passes with nothing to program
          res_status_nxt = ST_OK;
          state_nxt      = S_RES;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (rem_done) begin
          if (b_cross) begin
            res_status_nxt = ST_PAGE;
            state_nxt      = S_RES;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_VAL_ADDR;
          end
        end
      end
      S_VAL_ADDR: begin
        state_nxt = S_VAL_CHK;
      end
      S_VAL_CHK: begin
        if (bit_bad) begin
          res_status_nxt = ST_BITS;
          state_nxt      = S_RES;
        end else if (idx_inc == CMW'(b_count_r)) begin
          idx_nxt = '0;
          if (b_prefix_r == '0) begin
            res_status_nxt = ST_OK;
            res_intr_nxt   = 1'b1;
            state_nxt      = S_RES;
          end else begin
            state_nxt = S_COM_ADDR;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_VAL_ADDR;
        end
      end
      S_COM_ADDR: begin
        state_nxt = S_COM_WR;
      end
      S_COM_WR: begin
        if (idx_inc == CMW'(b_prefix_r)) begin
          res_status_nxt = ST_OK;
          res_pc_nxt     = b_prefix_r;
          res_intr_nxt   = CMW'(b_prefix_r) < CMW'(b_count_r);
          state_nxt      = S_RES;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_COM_ADDR;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: res_status_r, read_data: '0,
                            programmed_count: res_pc_r,
                            interrupted: res_intr_r, last_of_run: 1'b1};
          if (fin_r) begin
            b_count_nxt  = '0;
            b_start_nxt  = '0;
            b_prefix_nxt = '0;
            b_ovf_nxt    = 1'b0;
            fin_nxt      = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      b_count_r   <= '0;
      b_start_r   <= '0;
      b_prefix_r  <= '0;
      b_ovf_r     <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b_count_r   <= b_count_nxt;
      b_start_r   <= b_start_nxt;
      b_prefix_r  <= b_prefix_nxt;
      b_ovf_r     <= b_ovf_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rd_addr_r    <= rd_addr_nxt;
    rd_len_r     <= rd_len_nxt;
    res_status_r <= res_status_nxt;
    res_pc_r     <= res_pc_nxt;
    res_intr_r   <= res_intr_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --- submodules ----------------------------------------------------------
  nfpr_flash #(
    .MEM_BYTES(MEM_BYTES)
  ) u_flash (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fl_cmd),
    .addr  (fl_addr),
    .wdata (fl_wdata),
    .rdata (fl_rdata),
    .busy  (fl_busy)
  );

  nfpr_page_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (b_start_r),
    .divisor  (page_eff),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // --- assertions ----------------------------------------------------------
  a_commit_checked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COM_WR) |-> (!b_ovf_r && (CMW'(b_prefix_r) <= CMW'(b_count_r))))
    else $error("flash commit with unchecked burst");

  a_pbuf_count: assert property (@(posedge clk) disable iff (!rst_n)
    pb_we |=> (b_count_r == CW'($past(b_count_r) + 1'b1)))
    else $error("page buffer count did not advance");

  a_read_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_DATA) |-> (CMW'(idx_r) < CMW'(rd_len_r)))
    else $error("read index past run length");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fl_busy |-> ((state_r == S_IDLE) && !out_valid_r))
    else $error("activity during flash clearing pass");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for nor_flash_program_read_model_unit: a directed table, then random reads and
// program bursts, every result beat checked against a behavioral flash image.
// Depends on nfpr_pkg and the block under hw/rtl.
module testbench;
  import nfpr_pkg::*;

  localparam int FLASH_SIZE   = MEM_BYTES_DEF;
  localparam int PAGE_LIMIT   = PAGE_MAX_DEF;
  localparam int READ_LIMIT   = READ_MAX_DEF;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_BEATS   = 110;
  localparam int PHASES       = 6;
  localparam int MAX_LINES    = 30;

  typedef enum logic {OP_READ, OP_PROG} op_kind_t;
  typedef enum logic [1:0] {DM_RAND, DM_ZERO, DM_ONES, DM_STEP} fill_t;

  typedef struct {
    op_kind_t    kind;
    int unsigned addr;
    int unsigned len;
    int unsigned prefix;
    fill_t       fill;
    bit          close_empty;
    bit          cut_in;
    bit          typed;
    status_t     t_status;
    logic [7:0]  t_data;
    logic [8:0]  t_count;
    bit          t_intr;
  } op_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nor_flash_program_read_model_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // behavioral copy of the array, the page buffer and the burst bookkeeping
  logic [7:0]  flash_img [FLASH_SIZE];
  logic [7:0]  page_img [PAGE_LIMIT];
  int unsigned pb_count;
  int unsigned pb_start;
  int unsigned pb_prefix;
  bit          pb_over;
  logic [16:0] total_reg;
  logic [8:0]  page_reg;

  out_item_t beats_due [$];
  out_item_t want_beat;
  int        err_count = 0;
  int        beat_count = 0;
  int        tx_left = 0;
  int        rx_left = 0;
  int        rx_mode = 0;
  int        rx_hold = 0;
  int        rx_tick = 0;

  function automatic int unsigned total_eff();
    return (total_reg > FLASH_SIZE) ? FLASH_SIZE : total_reg;
  endfunction

  function automatic int unsigned page_eff();
    if (page_reg == 0) return 1;
    return (page_reg > PAGE_LIMIT) ? PAGE_LIMIT : page_reg;
  endfunction

  function automatic bit fits(int unsigned start, int unsigned len);
    int unsigned tot;
    tot = total_eff();
    return !(start > tot || len > tot - start);
  endfunction

  function automatic out_item_t result(status_t st, logic [7:0] rd, logic [8:0] pc,
                                       bit intr, bit last);
    out_item_t r;
    r.status           = st;
    r.read_data        = rd;
    r.programmed_count = pc;
    r.interrupted      = intr;
    r.last_of_run      = last;
    return r;
  endfunction

  // checks in order: overflow, prefix, bounds, page, bits; commit only if all pass
  function automatic status_t burst_close(output logic [8:0] pc, output bit intr);
    int unsigned pg;
    int unsigned i;
    pc   = '0;
    intr = 1'b0;
    if (pb_over) return ST_PAGE;
    if (pb_prefix > pb_count) return ST_PREFIX;
    if (!fits(pb_start, pb_count)) return ST_OOB;
    if (pb_count > 0) begin
      pg = page_eff();
      if (pb_start / pg != (pb_start + pb_count - 1) / pg) return ST_PAGE;
    end
    for (i = 0; i < pb_count; i++) begin
      if ((flash_img[pb_start + i] & page_img[i]) != page_img[i]) return ST_BITS;
    end
    for (i = 0; i < pb_prefix; i++) begin
      flash_img[pb_start + i] &= page_img[i];
    end
    pc   = 9'(pb_prefix);
    intr = (pb_prefix < pb_count);
    return ST_OK;
  endfunction

  function automatic void flash_step(in_item_t b);
    int unsigned len;
    int unsigned i;
    logic [8:0]  pc;
    bit          intr;
    status_t     st;
    if (!b.action && !b.burst_end) begin
      len = (b.read_length > READ_LIMIT) ? READ_LIMIT : b.read_length;
      if (!fits(b.address, len)) begin
        beats_due.push_back(result(ST_OOB, 8'h00, 9'd0, 1'b0, 1'b1));
      end else if (len == 0) begin
        beats_due.push_back(result(ST_OK, 8'h00, 9'd0, 1'b0, 1'b1));
      end else begin
        for (i = 0; i < len; i++) begin
          beats_due.push_back(result(ST_OK, flash_img[b.address + i], 9'd0, 1'b0,
                                     i + 1 == len));
        end
      end
      return;
    end
    // address and prefix come from the first beat of a burst
    if (pb_count == 0 && !pb_over) begin
      pb_start  = b.address;
      pb_prefix = b.prefix_count;
    end
    if (b.action) begin
      if (pb_count < PAGE_LIMIT) begin
        page_img[pb_count] = b.data_byte;
        pb_count++;
      end else begin
        pb_over = 1'b1;
      end
    end
    if (!b.burst_end) return;
    st = burst_close(pc, intr);
    beats_due.push_back(result(st, 8'h00, pc, intr, 1'b1));
    pb_count  = 0;
    pb_start  = 0;
    pb_prefix = 0;
    pb_over   = 1'b0;
  endfunction

  task automatic report(string what, int got, int want);
    err_count++;
    if (err_count <= MAX_LINES) begin
      $display("mismatch %s: got %0d, want %0d at %0t ns", what, got, want, $time);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        report("beat with nothing due, status", out_data.status, -1);
      end else begin
        want_beat = beats_due.pop_front();
        if (out_data.status !== want_beat.status)
          report("status", out_data.status, want_beat.status);
        if (out_data.read_data !== want_beat.read_data)
          report("read_data", out_data.read_data, want_beat.read_data);
        if (out_data.programmed_count !== want_beat.programmed_count)
          report("programmed_count", out_data.programmed_count, want_beat.programmed_count);
        if (out_data.interrupted !== want_beat.interrupted)
          report("interrupted", out_data.interrupted, want_beat.interrupted);
        if (out_data.last_of_run !== want_beat.last_of_run)
          report("last_of_run", out_data.last_of_run, want_beat.last_of_run);
      end
    end
  end

  // receiver: stretches of always-ready, coin flips, one-in-four, and short stall runs
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_tick % 4 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_hold = $urandom_range(1, 8);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // called and returns at a falling edge; predicts once the beat is taken
  task automatic send_beat(in_item_t b, bit typed, out_item_t want);
    int          gap;
    int unsigned n0;
    if (tx_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap     = 0;
        tx_left = $urandom_range(20, 60);
      end else begin
        gap     = $urandom_range(1, 6);
        tx_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    tx_left--;
    beat_count++;
    n0 = beats_due.size();
    flash_step(b);
    if (typed) begin
      while (beats_due.size() > n0) void'(beats_due.pop_back());
      beats_due.push_back(want);
    end
  endtask

  // sender holds off until every due beat is out, then lets the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    tx_left = 0;
    @(negedge clk);
    while (beats_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [16:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_TOTAL_BYTES) total_reg = v;
    else page_reg = v[8:0];
  endtask

  function automatic in_item_t noise_beat();
    in_item_t b;
    b.action       = 1'($urandom_range(0, 1));
    b.address      = 17'($urandom);
    b.read_length  = 7'($urandom);
    b.prefix_count = 9'($urandom);
    b.data_byte    = 8'($urandom);
    b.burst_end    = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic int unsigned pick_addr();
    int unsigned tot;
    int unsigned pg;
    int unsigned v;
    tot = total_eff();
    pg  = page_eff();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 1023);
      2: return ((tot >= 70) ? tot - 70 : 0) + $urandom_range(0, 72);
      3: return 17'($urandom);
      default: begin
        v = pg * $urandom_range(1, 1024 / pg + 1);
        return (v >= 3) ? v - $urandom_range(0, 3) : v;
      end
    endcase
  endfunction

  function automatic op_row_t row(op_kind_t k, int unsigned a, int unsigned n,
                                  int unsigned p, fill_t f, bit ce, bit ci, bit ty,
                                  status_t st, logic [7:0] d, logic [8:0] c, bit it);
    op_row_t r;
    r.kind        = k;
    r.addr        = a;
    r.len         = n;
    r.prefix      = p;
    r.fill        = f;
    r.close_empty = ce;
    r.cut_in      = ci;
    r.typed       = ty;
    r.t_status    = st;
    r.t_data      = d;
    r.t_count     = c;
    r.t_intr      = it;
    return r;
  endfunction

  // one read, or one program burst; fields the block ignores carry noise
  task automatic run_op(op_row_t r);
    in_item_t    b;
    in_item_t    rd;
    out_item_t   want;
    int unsigned i;
    bit          end_here;
    want = result(r.t_status, r.t_data, r.t_count, r.t_intr, 1'b1);
    if (r.kind == OP_READ) begin
      b             = noise_beat();
      b.action      = 1'b0;
      b.burst_end   = 1'b0;
      b.address     = 17'(r.addr);
      b.read_length = 7'(r.len);
      send_beat(b, r.typed, want);
      return;
    end
    for (i = 0; i < r.len; i++) begin
      b        = noise_beat();
      b.action = 1'b1;
      if (i == 0) begin
        b.address      = 17'(r.addr);
        b.prefix_count = 9'(r.prefix);
      end
      case (r.fill)
        DM_ZERO: b.data_byte = 8'h00;
        DM_ONES: b.data_byte = 8'hFF;
        DM_STEP: b.data_byte = 8'(i);
        default: ;
      endcase
      end_here    = (i + 1 == r.len) && !r.close_empty;
      b.burst_end = end_here;
      send_beat(b, r.typed && end_here, want);
      // a read in the middle of a burst sees the array before the commit
      if (r.cut_in && i == r.len / 2) begin
        rd             = noise_beat();
        rd.action      = 1'b0;
        rd.burst_end   = 1'b0;
        rd.address     = 17'(r.addr);
        rd.read_length = 7'd4;
        send_beat(rd, 1'b0, want);
      end
    end
    if (r.close_empty || r.len == 0) begin
      b           = noise_beat();
      b.action    = 1'b0;
      b.burst_end = 1'b1;
      if (r.len == 0) begin
        b.address      = 17'(r.addr);
        b.prefix_count = 9'(r.prefix);
      end
      send_beat(b, r.typed, want);
    end
  endtask

  task automatic random_op();
    op_row_t     r;
    int unsigned sel;
    int unsigned s;
    r   = row(OP_READ, pick_addr(), 0, 0, DM_RAND, 1'b0, 1'b0, 1'b0, ST_OK, 8'h00, 9'd0, 1'b0);
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      s = $urandom_range(0, 19);
      if (s < 12) r.len = $urandom_range(0, 16);
      else if (s < 17) r.len = $urandom_range(17, 64);
      else r.len = $urandom_range(65, 127);
      run_op(r);
    end else if (sel < 88) begin
      r.kind = OP_PROG;
      s = $urandom_range(0, 19);
      if (s < 16) r.len = $urandom_range(1, 8);
      else if (s < 19) r.len = $urandom_range(9, 40);
      else r.len = 0;
      s = $urandom_range(0, 19);
      if (s < 13) r.prefix = $urandom_range(0, r.len);
      else if (s < 16) r.prefix = r.len;
      else r.prefix = 9'($urandom);
      s = $urandom_range(0, 5);
      r.fill        = (s > 3) ? DM_RAND : fill_t'(s);
      r.close_empty = ($urandom_range(0, 4) == 0);
      r.cut_in      = ($urandom_range(0, 9) == 0);
      run_op(r);
    end else begin
      send_beat(noise_beat(), 1'b0, '0);
    end
  endtask

  initial begin
    in_item_t    b;
    op_row_t     dir_tab [$];
    logic [16:0] t;
    logic [8:0]  p;
    int          ph;
    int          goal;
    int unsigned k;

    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_TOTAL_BYTES;
    cfg_wdata = '0;

    for (k = 0; k < FLASH_SIZE; k++) flash_img[k] = 8'hFF;
    for (k = 0; k < PAGE_LIMIT; k++) page_img[k] = 8'h00;
    pb_count  = 0;
    pb_start  = 0;
    pb_prefix = 0;
    pb_over   = 1'b0;
    total_reg = TOTAL_RST;
    page_reg  = PAGE_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // kind, addr, len, prefix, fill, close by empty beat, read inside, typed, expectation
    dir_tab.push_back(row(OP_READ, 0, 1, 0, DM_RAND, 0, 0, 1, ST_OK, 8'hFF, 0, 0));
    dir_tab.push_back(row(OP_READ, 0, 0, 0, DM_RAND, 0, 0, 1, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 65535, 1, 0, DM_RAND, 0, 0, 1, ST_OK, 8'hFF, 0, 0));
    dir_tab.push_back(row(OP_READ, 65536, 0, 0, DM_RAND, 0, 0, 1, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 65536, 1, 0, DM_RAND, 0, 0, 1, ST_OOB, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 131071, 127, 0, DM_RAND, 0, 0, 1, ST_OOB, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 65472, 127, 0, DM_RAND, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 0, 4, 4, DM_STEP, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 0, 4, 0, DM_RAND, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 256, 8, 3, DM_ZERO, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 256, 8, 0, DM_RAND, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 256, 4, 4, DM_ONES, 0, 0, 1, ST_BITS, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 512, 3, 5, DM_RAND, 0, 0, 1, ST_PREFIX, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 250, 10, 10, DM_RAND, 0, 0, 1, ST_PAGE, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 65530, 10, 0, DM_RAND, 0, 0, 1, ST_OOB, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 768, 0, 0, DM_RAND, 1, 0, 1, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 768, 0, 1, DM_RAND, 1, 0, 1, ST_PREFIX, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 65537, 0, 0, DM_RAND, 1, 0, 1, ST_OOB, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 1024, 2, 2, DM_RAND, 1, 1, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 1024, 2, 0, DM_RAND, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 1280, 256, 256, DM_RAND, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    // one byte past the page buffer: overflow is rejected as a page crossing
    dir_tab.push_back(row(OP_PROG, 1536, 257, 0, DM_RAND, 0, 0, 1, ST_PAGE, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 1792, 5, 511, DM_RAND, 0, 0, 1, ST_PREFIX, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_READ, 1280, 64, 0, DM_RAND, 0, 0, 0, ST_OK, 8'h00, 0, 0));
    dir_tab.push_back(row(OP_PROG, 65535, 1, 1, DM_ZERO, 0, 0, 0, ST_OK, 8'h00, 0, 0));

    foreach (dir_tab[i]) run_op(dir_tab[i]);

    for (ph = 0; ph < PHASES; ph++) begin
      // registers change only with no burst open and the block quiet
      if (pb_count != 0 || pb_over) begin
        b           = noise_beat();
        b.action    = 1'b0;
        b.burst_end = 1'b1;
        send_beat(b, 1'b0, '0);
      end
      settle();
      case (ph)
        0: begin t = 17'h1FFFF; p = 9'd0; end
        1: begin t = 17'd4096; p = 9'd16; end
        2: begin t = 17'd0; p = 9'h1FF; end
        3: begin t = 17'($urandom); p = 9'($urandom); end
        4: begin t = TOTAL_RST; p = PAGE_RST; end
        default: begin t = 17'd1; p = 9'd1; end
      endcase
      set_reg(CFG_TOTAL_BYTES, t);
      set_reg(CFG_PAGE_BYTES, {8'd0, p});
      goal = beat_count + RAND_BEATS / PHASES;
      while (beat_count < goal) begin
        random_op();
        if ($urandom_range(0, 15) == 0) settle();
      end
    end

    settle();
    if (err_count == 0 && beats_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/nfpr_pkg.sv
hw/rtl/nfpr_flash.sv
hw/rtl/nfpr_page_rem.sv
hw/rtl/nor_flash_program_read_model_unit.sv
test/testbench.sv
